// File: sv/atapio_pkg.sv
// Shared types, register map and task-file constants for the ATA PIO sector sequencer.
// No dependencies; every other file of the block imports this package.
package atapio_pkg;

   // Sequencing constants
   localparam int WORDS_PER_SECTOR = 256;
   localparam int SETTLE_READS     = 4;
   localparam int WORD_IDX_W       = $clog2(WORDS_PER_SECTOR + 1);
   localparam int SETTLE_W         = 3;
   localparam logic [SETTLE_W-1:0] SETTLE_INIT = SETTLE_W'(SETTLE_READS - 1);
   localparam logic [WORD_IDX_W-1:0] WORD_LAST_IDX = WORD_IDX_W'(WORDS_PER_SECTOR - 1);

   // Widths of the configuration and field values
   localparam int LBA_W      = 28;
   localparam int POLL_W     = 17;
   localparam int PORT_W     = 16;
   localparam int DATA_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int PADDR_W    = 4;
   localparam int PDATA_W    = 32;
   localparam int MAX_RESULTS = 8;
   localparam int STEP_W     = $clog2(MAX_RESULTS);

   // Job queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Reset values of the configuration registers
   localparam logic [PORT_W-1:0] IO_BASE_RESET    = 16'd496;
   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 17'd100000;

   // Task-file register offsets
   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_FEATURES = 3'd1;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_LBA_LO   = 3'd3;
   localparam logic [2:0] REG_LBA_MID  = 3'd4;
   localparam logic [2:0] REG_LBA_HI   = 3'd5;
   localparam logic [2:0] REG_DEVICE   = 3'd6;
   localparam logic [2:0] REG_STATUS   = 3'd7;

   // Status bits
   localparam int ST_BSY = 7;
   localparam int ST_DF  = 5;
   localparam int ST_DRQ = 3;
   localparam int ST_ERR = 0;

   // Command and device bytes
   localparam logic [7:0] ATA_CMD_READ  = 8'h20;
   localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
   localparam logic [7:0] ATA_CMD_FLUSH = 8'hE7;
   localparam logic [7:0] ATA_DEV_LBA   = 8'hE0;

   typedef enum logic [1:0] {
      CMD_START_RD = 2'd0,
      CMD_START_WR = 2'd1,
      CMD_REPLY    = 2'd2,
      CMD_WORD     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_BUS  = 2'd0,
      KIND_WORD = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_IO_BASE    = 2'd0,
      CSR_DRIVE      = 2'd1,
      CSR_POLL_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_SETTLE  = 4'd1,
      PH_POLL    = 4'd2,
      PH_RDATA   = 4'd3,
      PH_WDATA   = 4'd4,
      PH_FSETTLE = 4'd5
   } phase_type;

   // What the back end has to emit for one input item
   typedef enum logic [3:0] {
      OP_DONE_FAIL      = 4'd0,
      OP_DONE_OK        = 4'd1,
      OP_STATUS_RD      = 4'd2,
      OP_DATA_RD        = 4'd3,
      OP_TASKFILE       = 4'd4,
      OP_DELIVER_DATA   = 4'd5,
      OP_DELIVER_STATUS = 4'd6,
      OP_DELIVER_DONE   = 4'd7,
      OP_WORD           = 4'd8,
      OP_WORD_FLUSH     = 4'd9
   } job_op_type;

   typedef struct packed {
      logic [PORT_W-1:0] io_base;
      logic              drive_slave;
      logic [POLL_W-1:0] poll_limit;
   } cfg_type;

   typedef struct packed {
      job_op_type        op;
      logic [DATA_W-1:0] data;
      logic [LBA_W-1:0]  lba;
      logic              is_write;
   } job_type;

endpackage

// File: sv/atapio_csr.sv
// Configuration registers of the ATA PIO sequencer behind an APB-style port.
// Depends on atapio_pkg for the register map and the cfg_type bundle.
module atapio_csr
   import atapio_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [PORT_W-1:0] io_base_ff, io_base_in;
   logic              drive_ff, drive_in;
   logic [POLL_W-1:0] poll_limit_ff, poll_limit_in;
   logic              wr_transfer;
   csr_index_type     index;

   assign pready      = 1'b1;
   assign index       = csr_index_type'(paddr[PADDR_W-1:2]);
   assign wr_transfer = psel && penable && pwrite && pready;

   // Decode the write
   always_comb begin
      io_base_in    = io_base_ff;
      drive_in      = drive_ff;
      poll_limit_in = poll_limit_ff;
      if (wr_transfer) begin
         unique case (index)
            CSR_IO_BASE:    io_base_in    = pwdata[PORT_W-1:0];
            CSR_DRIVE:      drive_in      = pwdata[0];
            CSR_POLL_LIMIT: poll_limit_in = pwdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_base_ff    <= IO_BASE_RESET;
         drive_ff      <= 1'b0;
         poll_limit_ff <= POLL_LIMIT_RESET;
      end else begin
         io_base_ff    <= io_base_in;
         drive_ff      <= drive_in;
         poll_limit_ff <= poll_limit_in;
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         CSR_IO_BASE:    prdata = PDATA_W'(io_base_ff);
         CSR_DRIVE:      prdata = PDATA_W'(drive_ff);
         CSR_POLL_LIMIT: prdata = PDATA_W'(poll_limit_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.io_base     = io_base_ff;
   assign cfg.drive_slave = drive_ff;
   assign cfg.poll_limit  = poll_limit_ff;

endmodule

// File: sv/atapio_front.sv
// Front end: holds the sector sequencing state, classifies each accepted item
// and issues at most one job per item. Depends on atapio_pkg.
module atapio_front
   import atapio_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                take,
   input  logic [1:0]          cmd,
   input  logic [31:0]         lba,
   input  logic [COUNT_W-1:0]  sector_count,
   input  logic [DATA_W-1:0]   data_in,
   output logic                job_push,
   output job_type             job
);

   phase_type             phase_ff, phase_in;
   logic                  is_write_ff, is_write_in;
   logic [LBA_W-1:0]      lba_ff, lba_in;
   logic [COUNT_W-1:0]    sectors_ff, sectors_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic [SETTLE_W-1:0]   settle_ff, settle_in;
   logic [POLL_W-1:0]     polls_ff, polls_in;

   cmd_type            c;
   logic [7:0]         st;
   logic               is_start, is_reply, is_word;
   logic               lba_bad, cnt_zero, start_go;
   logic               st_ready, st_fail, poll_out;
   logic               word_last, settle_more, sectors_nz, more_after;
   logic [COUNT_W-1:0] sectors_dec;

   // Shared conditions
   assign c           = cmd_type'(cmd);
   assign st          = data_in[7:0];
   assign is_start    = take && (c == CMD_START_RD || c == CMD_START_WR);
   assign is_reply    = take && (c == CMD_REPLY);
   assign is_word     = take && (c == CMD_WORD);
   assign lba_bad     = |lba[31:LBA_W];
   assign cnt_zero    = (sector_count == '0);
   assign start_go    = !lba_bad && !cnt_zero;
   assign st_ready    = !st[ST_BSY] && st[ST_DRQ];
   assign st_fail     = !st[ST_BSY] && (st[ST_ERR] || st[ST_DF]);
   assign poll_out    = (polls_ff >= cfg.poll_limit);
   assign word_last   = (word_ff == WORD_LAST_IDX);
   assign settle_more = (settle_ff != '0);
   assign sectors_nz  = (sectors_ff != '0);
   assign sectors_dec = sectors_ff - COUNT_W'(1);
   assign more_after  = (sectors_dec != '0);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:
            if (is_start && start_go) phase_in = PH_SETTLE;
         PH_SETTLE:
            if (is_reply && !settle_more) phase_in = PH_POLL;
         PH_POLL:
            if (is_reply) begin
               priority if (st_ready) phase_in = is_write_ff ? PH_WDATA : PH_RDATA;
               else if (st_fail || poll_out) phase_in = PH_IDLE;
               else phase_in = PH_POLL;
            end
         PH_RDATA:
            if (is_reply && word_last) phase_in = more_after ? PH_SETTLE : PH_IDLE;
         PH_WDATA:
            if (is_word && word_last) phase_in = PH_FSETTLE;
         PH_FSETTLE:
            if (is_reply && !settle_more) phase_in = sectors_nz ? PH_SETTLE : PH_IDLE;
         default:
            phase_in = PH_IDLE;
      endcase
   end

   // Next values of the sector counters
   always_comb begin
      is_write_in = is_write_ff;
      lba_in      = lba_ff;
      sectors_in  = sectors_ff;
      word_in     = word_ff;
      settle_in   = settle_ff;
      polls_in    = polls_ff;
      unique case (phase_ff)
         PH_IDLE:
            if (is_start && start_go) begin
               is_write_in = (c == CMD_START_WR);
               lba_in      = lba[LBA_W-1:0];
               sectors_in  = sector_count;
               word_in     = '0;
               polls_in    = '0;
               settle_in   = SETTLE_INIT;
            end
         PH_SETTLE:
            if (is_reply) begin
               if (settle_more) settle_in = settle_ff - SETTLE_W'(1);
               else             polls_in  = POLL_W'(1);
            end
         PH_POLL:
            if (is_reply) begin
               priority if (st_ready) word_in = '0;
               else if (st_fail || poll_out) polls_in = polls_ff;
               else polls_in = polls_ff + POLL_W'(1);
            end
         PH_RDATA:
            if (is_reply) begin
               word_in = word_ff + WORD_IDX_W'(1);
               if (word_last) begin
                  sectors_in = sectors_dec;
                  lba_in     = lba_ff + LBA_W'(1);
                  word_in    = '0;
                  if (more_after) settle_in = SETTLE_INIT;
               end
            end
         PH_WDATA:
            if (is_word) begin
               word_in = word_ff + WORD_IDX_W'(1);
               if (word_last) begin
                  sectors_in = sectors_dec;
                  lba_in     = lba_ff + LBA_W'(1);
                  word_in    = '0;
                  settle_in  = SETTLE_INIT;
               end
            end
         PH_FSETTLE:
            if (is_reply) begin
               if (settle_more)     settle_in = settle_ff - SETTLE_W'(1);
               else if (sectors_nz) settle_in = SETTLE_INIT;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         is_write_ff <= 1'b0;
         lba_ff      <= '0;
         sectors_ff  <= '0;
         word_ff     <= '0;
         settle_ff   <= '0;
         polls_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         is_write_ff <= is_write_in;
         lba_ff      <= lba_in;
         sectors_ff  <= sectors_in;
         word_ff     <= word_in;
         settle_ff   <= settle_in;
         polls_ff    <= polls_in;
      end
   end

   // Job for the back end
   always_comb begin
      job_push     = 1'b0;
      job.op       = OP_STATUS_RD;
      job.data     = data_in;
      job.lba      = lba_ff;
      job.is_write = is_write_ff;
      unique case (phase_ff)
         PH_IDLE:
            if (is_start) begin
               job_push = 1'b1;
               priority if (lba_bad) job.op = OP_DONE_FAIL;
               else if (cnt_zero) job.op = OP_DONE_OK;
               else job.op = OP_STATUS_RD;
            end
         PH_SETTLE:
            if (is_reply) begin
               job_push = 1'b1;
               job.op   = settle_more ? OP_STATUS_RD : OP_TASKFILE;
            end
         PH_POLL:
            if (is_reply) begin
               priority if (st_ready) begin
                  job_push = !is_write_ff;
                  job.op   = OP_DATA_RD;
               end else if (st_fail || poll_out) begin
                  job_push = 1'b1;
                  job.op   = OP_DONE_FAIL;
               end else begin
                  job_push = 1'b1;
                  job.op   = OP_STATUS_RD;
               end
            end
         PH_RDATA:
            if (is_reply) begin
               job_push = 1'b1;
               priority if (!word_last) job.op = OP_DELIVER_DATA;
               else if (more_after) job.op = OP_DELIVER_STATUS;
               else job.op = OP_DELIVER_DONE;
            end
         PH_WDATA:
            if (is_word) begin
               job_push = 1'b1;
               job.op   = word_last ? OP_WORD_FLUSH : OP_WORD;
            end
         PH_FSETTLE:
            if (is_reply) begin
               job_push = 1'b1;
               job.op   = (settle_more || sectors_nz) ? OP_STATUS_RD : OP_DONE_OK;
            end
         default: ;
      endcase
   end

endmodule

// File: sv/atapio_job_fifo.sv
// Short job queue that decouples the front end from the back end.
// Depends on atapio_pkg for job_type and the queue depth.
module atapio_job_fifo
   import atapio_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop)      count_in = count_ff + FIFO_CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// File: sv/atapio_back.sv
// Back end: expands each job into its result transfers, one per cycle, into
// the result register while it is free or drains. Depends on atapio_pkg encodings.
module atapio_back
   import atapio_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              job_valid,
   input  job_type           job,
   output logic              job_pop,
   output logic              empty,
   input  logic              pop,
   output logic [1:0]        rsp_kind,
   output logic              rsp_bus_write,
   output logic              rsp_word_access,
   output logic [PORT_W-1:0] rsp_port,
   output logic [DATA_W-1:0] rsp_data_out,
   output logic              rsp_ok,
   output logic              rsp_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic              bus_write_ff, word_ff, ok_ff, last_ff;
   logic [PORT_W-1:0] port_ff;
   logic [DATA_W-1:0] data_ff;

   kind_type          r_kind;
   logic              r_wr, r_wd, r_ok, r_final;
   logic [2:0]        r_off;
   logic [DATA_W-1:0] r_data;
   logic [PORT_W-1:0] r_port;
   logic              advance;
   logic [7:0]        dev_byte, cmd_byte;

   assign dev_byte = ATA_DEV_LBA | {3'b000, cfg.drive_slave, job.lba[LBA_W-1:24]};
   assign cmd_byte = job.is_write ? ATA_CMD_WRITE : ATA_CMD_READ;

   // Result for the current job and step
   always_comb begin
      r_kind  = KIND_BUS;
      r_wr    = 1'b0;
      r_wd    = 1'b0;
      r_off   = REG_STATUS;
      r_data  = '0;
      r_ok    = 1'b0;
      r_final = 1'b1;
      unique case (job.op)
         OP_DONE_FAIL: r_kind = KIND_DONE;
         OP_DONE_OK: begin
            r_kind = KIND_DONE;
            r_ok   = 1'b1;
         end
         OP_STATUS_RD: ;
         OP_DATA_RD: begin
            r_off = REG_DATA;
            r_wd  = 1'b1;
         end
         OP_TASKFILE: begin
            r_wr    = 1'b1;
            r_final = (step_ff == STEP_W'(MAX_RESULTS - 1));
            unique case (step_ff)
               3'd0: begin r_off = REG_DEVICE;   r_data = {8'h00, dev_byte}; end
               3'd1: begin r_off = REG_FEATURES; r_data = '0; end
               3'd2: begin r_off = REG_COUNT;    r_data = 16'h0001; end
               3'd3: begin r_off = REG_LBA_LO;   r_data = {8'h00, job.lba[7:0]}; end
               3'd4: begin r_off = REG_LBA_MID;  r_data = {8'h00, job.lba[15:8]}; end
               3'd5: begin r_off = REG_LBA_HI;   r_data = {8'h00, job.lba[23:16]}; end
               3'd6: begin r_off = REG_STATUS;   r_data = {8'h00, cmd_byte}; end
               default: begin
                  r_wr  = 1'b0;
                  r_off = REG_STATUS;
               end
            endcase
         end
         OP_DELIVER_DATA, OP_DELIVER_STATUS, OP_DELIVER_DONE: begin
            r_final = (step_ff != '0);
            if (step_ff == '0) begin
               r_kind = KIND_WORD;
               r_data = job.data;
            end else if (job.op == OP_DELIVER_DATA) begin
               r_off = REG_DATA;
               r_wd  = 1'b1;
            end else if (job.op == OP_DELIVER_DONE) begin
               r_kind = KIND_DONE;
               r_ok   = 1'b1;
            end
         end
         OP_WORD: begin
            r_wr   = 1'b1;
            r_wd   = 1'b1;
            r_off  = REG_DATA;
            r_data = job.data;
         end
         OP_WORD_FLUSH: begin
            r_final = (step_ff == STEP_W'(2));
            unique case (step_ff)
               3'd0: begin
                  r_wr   = 1'b1;
                  r_wd   = 1'b1;
                  r_off  = REG_DATA;
                  r_data = job.data;
               end
               3'd1: begin
                  r_wr   = 1'b1;
                  r_data = {8'h00, ATA_CMD_FLUSH};
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign r_port = (r_kind == KIND_BUS) ? cfg.io_base + PORT_W'(r_off) : '0;

   // Hand over a result whenever the result register is free or drains
   assign advance  = job_valid && (!valid_ff || pop);
   assign job_pop  = advance && r_final;
   assign valid_in = advance || (valid_ff && !pop);
   assign step_in  = advance ? (r_final ? '0 : step_ff + STEP_W'(1)) : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff      <= r_kind;
         bus_write_ff <= r_wr;
         word_ff      <= r_wd;
         port_ff      <= r_port;
         data_ff      <= r_data;
         ok_ff        <= r_ok;
         last_ff      <= r_final;
      end
   end

   assign empty           = !valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_bus_write   = bus_write_ff;
   assign rsp_word_access = word_ff;
   assign rsp_port        = port_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_last        = last_ff;

endmodule

// File: sv/ata_pio_sector_sequencer.sv
// Top level of the ATA PIO LBA28 sector sequencer: configuration registers,
// front end, job queue and back end. Depends on atapio_pkg and all atapio_* modules.
//
//   channel   direction  transfer when            content
//   req_*     in         push && !full            command, lba, count, reply/word data
//   rsp_*     out        pop && !empty            bus access, read word or done status
//   csr       in/out     psel&penable&pwrite      io_base, drive_slave, poll_limit
//
// The front end takes one item per cycle while the four-entry job queue has room.
// While its output register is free or popped, the back end sends one result per cycle:
// one or two for most items, eight for a task-file issue, three for a sector's last write word.
// A result waits in the output register without holding up intake until the queue fills.
// Reset is synchronous and returns to idle with the configuration at its defaults.
module ata_pio_sector_sequencer
   import atapio_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_lba,
   input  logic [COUNT_W-1:0] req_sector_count,
   input  logic [DATA_W-1:0]  req_data_in,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_kind,
   output logic               rsp_bus_write,
   output logic               rsp_word_access,
   output logic [PORT_W-1:0]  rsp_port,
   output logic [DATA_W-1:0]  rsp_data_out,
   output logic               rsp_ok,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type cfg;
   logic    take;
   logic    job_push, job_pop, job_valid, fifo_full;
   job_type new_job, head_job;

   assign full = fifo_full;
   assign take = push && !fifo_full;

   atapio_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   atapio_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .take         (take),
      .cmd          (req_cmd),
      .lba          (req_lba),
      .sector_count (req_sector_count),
      .data_in      (req_data_in),
      .job_push     (job_push),
      .job          (new_job)
   );

   atapio_job_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (new_job),
      .full       (fifo_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_job   (head_job)
   );

   atapio_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .job_valid       (job_valid),
      .job             (head_job),
      .job_pop         (job_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_bus_write   (rsp_bus_write),
      .rsp_word_access (rsp_word_access),
      .rsp_port        (rsp_port),
      .rsp_data_out    (rsp_data_out),
      .rsp_ok          (rsp_ok),
      .rsp_last        (rsp_last)
   );

endmodule
